### hw/rtl/slanted_ray_shadow_grid_core_assert.svh
// Assertion macros for the slanted-ray shadow grid core.
// Used by the top level; needs nothing else.
`ifndef SLANTED_RAY_SHADOW_GRID_CORE_ASSERT_SVH
`define SLANTED_RAY_SHADOW_GRID_CORE_ASSERT_SVH

// Same-cycle implication under an active-low reset.
`define SSG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under an active-low reset.
`define SSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ssg_pkg.sv
// Shared types and constants of the slanted-ray shadow grid.
// No dependencies.
`default_nettype none

package ssg_pkg;

  localparam int unsigned FRAC_BITS = 4;
  localparam int unsigned HALF_STEP = 1 << (FRAC_BITS - 1);
  localparam int unsigned ACC_W     = 11;  // 127 * 16 + HALF_STEP fits
  localparam int unsigned OFF_W     = ACC_W - FRAC_BITS;
  localparam int unsigned SRC_W     = 9;   // signed source column

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_SUN  = 2'd1,
    STATUS_GRID = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_SUN_STRENGTH = 2'd0,
    CFG_RAY_SLOPE    = 2'd1,
    CFG_LIGHT_FLOOR  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic       in_range;
    logic [7:0] src_col;
  } ray_t;

endpackage

`default_nettype wire

### hw/rtl/ssg_if.sv
// Valid/ready channel interfaces for the shadow grid items.
// No dependencies.
`default_nettype none

interface ssg_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [3:0] cell_row;
  logic [4:0] cell_column;
  logic [7:0] shade_value;

  modport source (output valid, opcode, cell_row, cell_column, shade_value, input ready);
  modport sink   (input valid, opcode, cell_row, cell_column, shade_value, output ready);
endinterface

interface ssg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] light_level;
  logic [1:0] status;

  modport source (output valid, light_level, status, input ready);
  modport sink   (input valid, light_level, status, output ready);
endinterface

`default_nettype wire

### hw/rtl/slanted_ray_shadow_grid_core.sv
// Slanted-ray shadow grid core: sequencer, config registers and result register.
// Depends on ssg_pkg, ssg_if, ssg_shade_mem, ssg_ray_unit and the assert header.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+-------------------------------------------
//   in_i     | in  | valid / ready      | opcode, cell_row, cell_column, shade_value
//   out_o    | out | valid / ready      | light_level, status
//   cfg      | in  | cfg_we_i (no wait) | cfg_idx_i, cfg_data_i
//
// A write or a rejected query goes from idle straight to the output register to wait.
// A query walks one grid row per cycle through the single memory read port and ends early
// when the ray leaves the grid or the shade saturates. After reset a clearing pass writes
// zero to all GRID_ROWS * GRID_COLUMNS cells, one per cycle; no item is taken meanwhile,
// config writes still are. One item is in flight at a time; a stalled result holds the
// input off.
`default_nettype none
`include "slanted_ray_shadow_grid_core_assert.svh"

module slanted_ray_shadow_grid_core #(
  parameter int unsigned GRID_ROWS     = 16,
  parameter int unsigned GRID_COLUMNS  = 32,
  parameter int          MAX_RAY_SLOPE = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  ssg_in_if.sink          in_i,
  ssg_out_if.source       out_o
);

  localparam int unsigned CELLS = GRID_ROWS * GRID_COLUMNS;
  localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_e;

  // Configuration registers.
  logic        [7:0] sun_strength_q;
  logic signed [7:0] ray_slope_q;
  logic        [7:0] light_floor_q;

  // Sequencer state.
  state_e                    state_q, state_d;
  logic [AW-1:0]             clr_q, clr_d;
  logic [4:0]                col_q, col_d;
  logic [3:0]                row_q, row_d;
  logic [4:0]                dist_q, dist_d;
  logic                      neg_q, neg_d;
  logic [7:0]                mag_q, mag_d;
  logic [ssg_pkg::ACC_W-1:0] acc_q, acc_d;
  logic [AW-1:0]             base_q, base_d;
  logic [7:0]                sum_q, sum_d;
  logic                      pend_q, pend_d;
  logic                      stop_q, stop_d;
  logic [7:0]                light_q, light_d;
  ssg_pkg::status_e          status_q, status_d;

  // Memory port.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  ssg_pkg::ray_t ray;
  logic          accept;
  logic          in_grid;
  logic          sun_bad;
  logic [7:0]    limit;
  logic [8:0]    sum_next;
  logic          go;
  logic          sat;

  ssg_shade_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ssg_ray_unit #(
    .GRID_COLUMNS (GRID_COLUMNS)
  ) u_ray (
    .acc_i (acc_q),
    .neg_i (neg_q),
    .col_i (col_q),
    .ray_o (ray)
  );

  // Config writes land whenever the enable is high; unknown indexes drop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sun_strength_q <= 8'd255;
      ray_slope_q    <= 8'sd0;
      light_floor_q  <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ssg_pkg::CFG_SUN_STRENGTH: sun_strength_q <= cfg_data_i;
        ssg_pkg::CFG_RAY_SLOPE:    ray_slope_q    <= $signed(cfg_data_i);
        ssg_pkg::CFG_LIGHT_FLOOR:  light_floor_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = (state_q == ST_DONE);
  assign out_o.light_level = light_q;
  assign out_o.status      = status_q;

  assign accept  = in_i.valid && in_i.ready;
  assign in_grid = (32'(in_i.cell_row) < GRID_ROWS) && (32'(in_i.cell_column) < GRID_COLUMNS);
  assign sun_bad = (sun_strength_q < light_floor_q) ||
                   (int'(ray_slope_q) < -MAX_RAY_SLOPE) ||
                   (int'(ray_slope_q) > MAX_RAY_SLOPE);
  assign limit   = sun_strength_q - light_floor_q;

  // Walk step: issue the read for this distance while the previous read adds up.
  assign go        = !stop_q && (dist_q <= {1'b0, row_q}) && ray.in_range;
  assign mem_raddr = base_q + AW'(ray.src_col);
  assign sum_next  = {1'b0, sum_q} + {1'b0, mem_rdata};
  assign sat       = pend_q && (sum_next >= {1'b0, limit});

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    col_d    = col_q;
    row_d    = row_q;
    dist_d   = dist_q;
    neg_d    = neg_q;
    mag_d    = mag_q;
    acc_d    = acc_q;
    base_d   = base_q;
    sum_d    = sum_q;
    pend_d   = pend_q;
    stop_d   = stop_q;
    light_d  = light_q;
    status_d = status_q;
    mem_we    = 1'b0;
    mem_waddr = AW'(32'(in_i.cell_row) * GRID_COLUMNS + 32'(in_i.cell_column));
    mem_wdata = in_i.shade_value;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = 8'd0;
        clr_d     = clr_q + AW'(1);
        if (32'(clr_q) == CELLS - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          light_d  = 8'd0;
          status_d = ssg_pkg::STATUS_OK;
          state_d  = ST_DONE;
          if (in_i.opcode == ssg_pkg::OP_WRITE) begin
            if (in_grid) begin
              mem_we = 1'b1;
            end else begin
              status_d = ssg_pkg::STATUS_GRID;
            end
          end else if (sun_bad) begin
            status_d = ssg_pkg::STATUS_SUN;
          end else if (!in_grid) begin
            status_d = ssg_pkg::STATUS_GRID;
          end else begin
            // Start the walk at distance one, one row above the cell.
            row_d   = in_i.cell_row;
            col_d   = in_i.cell_column;
            neg_d   = ray_slope_q[7];
            mag_d   = ray_slope_q[7] ? 8'(-ray_slope_q) : 8'(ray_slope_q);
            acc_d   = ssg_pkg::ACC_W'(mag_d);
            dist_d  = 5'd1;
            base_d  = AW'(32'(in_i.cell_row) * GRID_COLUMNS - GRID_COLUMNS);
            sum_d   = 8'd0;
            pend_d  = 1'b0;
            stop_d  = 1'b0;
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (go) begin
          dist_d = dist_q + 5'd1;
          acc_d  = acc_q + ssg_pkg::ACC_W'(mag_q);
          base_d = base_q - AW'(GRID_COLUMNS);
          pend_d = 1'b1;
        end else begin
          stop_d = 1'b1;
          pend_d = 1'b0;
        end
        if (pend_q) begin
          sum_d = sum_next[7:0];
        end
        if (sat) begin
          // Saturated shade ends the walk at the floor.
          light_d = sun_strength_q - limit;
          state_d = ST_DONE;
        end else if (!go && !pend_q) begin
          light_d = sun_strength_q - sum_q;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
      stop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
      stop_q  <= stop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_d_hold: begin
      col_q    <= col_d;
      row_q    <= row_d;
      dist_q   <= dist_d;
      neg_q    <= neg_d;
      mag_q    <= mag_d;
      acc_q    <= acc_d;
      base_q   <= base_d;
      sum_q    <= sum_d;
      light_q  <= light_d;
      status_q <= status_d;
    end
  end

  // A waiting result holds the input side off.
  `SSG_ASSERT_NOW(a_no_accept_while_result, clk_i, rst_ni,
    out_o.valid, !in_i.ready, "input ready while a result waits")

  // Every accepted item leaves the idle state at once.
  `SSG_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni,
    accept, !in_i.ready, "block still ready after taking an item")

  // Error results carry no light level.
  `SSG_ASSERT_NOW(a_error_zero_light, clk_i, rst_ni,
    out_o.valid && (out_o.status != ssg_pkg::STATUS_OK), out_o.light_level == 8'd0,
    "error result with nonzero light level")

endmodule

`default_nettype wire

### hw/rtl/ssg_shade_mem.sv
// Shade byte memory: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module ssg_shade_mem #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### hw/rtl/ssg_ray_unit.sv
// Ray step unit: rounds the accumulated Q4 offset and checks the source column.
// Depends on ssg_pkg.
`default_nettype none

module ssg_ray_unit #(
  parameter int unsigned GRID_COLUMNS = 32
) (
  input  wire logic [ssg_pkg::ACC_W-1:0] acc_i,
  input  wire logic                      neg_i,
  input  wire logic [4:0]                col_i,
  output ssg_pkg::ray_t                  ray_o
);

  logic [ssg_pkg::ACC_W-1:0]        rounded;
  logic [ssg_pkg::OFF_W-1:0]        off;
  logic signed [ssg_pkg::SRC_W-1:0] src;

  always_comb begin
    // Round half away from zero on the magnitude, then apply the sign.
    rounded = acc_i + ssg_pkg::ACC_W'(ssg_pkg::HALF_STEP);
    off     = rounded[ssg_pkg::ACC_W-1:ssg_pkg::FRAC_BITS];
    if (neg_i) begin
      src = $signed(ssg_pkg::SRC_W'(col_i)) + $signed(ssg_pkg::SRC_W'(off));
    end else begin
      src = $signed(ssg_pkg::SRC_W'(col_i)) - $signed(ssg_pkg::SRC_W'(off));
    end
    ray_o.in_range = !src[ssg_pkg::SRC_W-1] && (int'(src) < int'(GRID_COLUMNS));
    ray_o.src_col  = src[7:0];
  end

endmodule

`default_nettype wire
